[rtl/bfba_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared types and constants of the best-fit block allocator: item layouts,
// opcodes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package bfba_pkg;

    // Field widths of the items on the ports
    localparam int OPCODE_W     = 2;
    localparam int SIZE_FIELD_W = 16;
    localparam int STATUS_W     = 2;
    localparam int INDEX_FIELD_W = 4;
    localparam int REQNUM_W     = 16;

    // Defaults of the top-level parameters
    localparam int BFBA_MAX_BLOCKS = 16;
    localparam int BFBA_SIZE_BITS  = 16;

    // Opcodes of an input item
    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_ALLOC  = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    // Status codes of a result item
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]     opcode;
        logic [SIZE_FIELD_W-1:0] size;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [INDEX_FIELD_W-1:0] block_index;
        logic [SIZE_FIELD_W-1:0]  remaining_size;
        logic [REQNUM_W-1:0]      request_number;
    } t_out_item;

    // Control of the shared compare unit
    typedef struct packed {
        logic start;   // forget the current best candidate
        logic vld;     // a table entry is presented this cycle
    } t_cmp_ctl;

endpackage : bfba_pkg
`default_nettype wire

[rtl/best_fit_block_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a table of free-block sizes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one command:
//   clear, append a free block, allocate a request, or no-op. Output channel
//   (o_out_valid / i_out_stall / o_out_item) gives one result per command.
//   Clear, append, no-op and an allocate on an empty table go from accept
//   straight to the finish state, which loads the output register once it
//   is free. Other allocates first pass the scan, wait and update states
//   over the N loaded blocks: the table memory has one read port and the
//   compare unit examines one entry per cycle, then the update state
//   writes the shrunk block back if one fits. The block takes one command at a
//   time; o_in_stall is high while a command is in work.
//   The result sits in an output register, so a new command is accepted while
//   the previous result still waits. If the receiver stalls and a further
//   result is finished, that result waits in the block and the input stalls.
//   Reset empties the table, zeroes the request counter and drops any
//   pending result; table contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module best_fit_block_allocator
    import bfba_pkg::*;
#(
    parameter int MAX_BLOCKS = BFBA_MAX_BLOCKS,
    parameter int SIZE_BITS  = BFBA_SIZE_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BLOCKS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_WAIT = 5'b00100,
        S_UPD  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_loaded, n_loaded;
    logic [REQNUM_W-1:0]  r_reqs, n_reqs;
    logic [IDX_W-1:0]     r_scan, n_scan;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [SIZE_BITS-1:0] r_req_sz, n_req_sz;
    t_out_item            r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic                 accept;
    logic [SIZE_BITS-1:0] in_sz;
    logic [SIZE_BITS+SIZE_FIELD_W-1:0] in_sz_ext;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [SIZE_BITS-1:0] rd_data;
    t_cmp_ctl             cmp_ctl;
    logic                 cmp_found;
    logic [IDX_W-1:0]     cmp_idx;
    logic [SIZE_BITS-1:0] cmp_rem;
    logic [IDX_W+INDEX_FIELD_W-1:0]     idx_ext_app, idx_ext_best;
    logic [SIZE_BITS+SIZE_FIELD_W-1:0]  sz_ext_app, sz_ext_rem;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // Take the size modulo the table width
    assign in_sz_ext = {{SIZE_BITS{1'b0}}, i_in_item.size};
    assign in_sz     = in_sz_ext[SIZE_BITS-1:0];

    // Width adjust of indexes and sizes onto the result fields
    assign idx_ext_app  = {{INDEX_FIELD_W{1'b0}}, r_loaded[IDX_W-1:0]};
    assign idx_ext_best = {{INDEX_FIELD_W{1'b0}}, cmp_idx};
    assign sz_ext_app   = {{SIZE_FIELD_W{1'b0}}, in_sz};
    assign sz_ext_rem   = {{SIZE_FIELD_W{1'b0}}, cmp_rem};

    assign rd_en = (r_state == S_SCAN);
    assign cmp_ctl.start = accept;
    assign cmp_ctl.vld   = r_rd_vld;

    bfba_mem #(
        .DEPTH  (MAX_BLOCKS),
        .DATA_W (SIZE_BITS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_scan),
        .o_rd_data (rd_data)
    );

    bfba_cmp #(
        .DATA_W (SIZE_BITS),
        .IDX_W  (IDX_W)
    ) u_cmp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (cmp_ctl),
        .i_data      (rd_data),
        .i_idx       (r_rd_idx),
        .i_req       (r_req_sz),
        .o_found     (cmp_found),
        .o_best_idx  (cmp_idx),
        .o_remaining (cmp_rem)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_reqs      = r_reqs;
        n_scan      = r_scan;
        n_req_sz    = r_req_sz;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_loaded[IDX_W-1:0];
        wr_data     = in_sz;

        // Drop the delivered result
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res    = '0;
                    n_req_sz = in_sz;
                    n_scan   = '0;
                    n_state  = S_FIN;
                    unique case (t_opcode'(i_in_item.opcode))
                        OP_CLEAR: begin
                            n_loaded = '0;
                            n_reqs   = '0;
                        end
                        OP_APPEND: begin
                            if (r_loaded == CNT_FULL) begin
                                n_res.status = ST_FULL;
                            end else begin
                                wr_en                = 1'b1;
                                n_loaded             = r_loaded + 1'b1;
                                n_res.status         = ST_DONE;
                                n_res.block_index    = idx_ext_app[INDEX_FIELD_W-1:0];
                                n_res.remaining_size = sz_ext_app[SIZE_FIELD_W-1:0];
                            end
                        end
                        OP_ALLOC: begin
                            n_reqs               = r_reqs + 1'b1;
                            n_res.request_number = r_reqs + 1'b1;
                            if (r_loaded == '0) begin
                                n_res.status = ST_NOFIT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_NOP: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Advance the read address over the loaded entries
                n_scan = r_scan + 1'b1;
                if (CNT_W'(r_scan) + 1'b1 == r_loaded) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                // Shrink the chosen block
                if (cmp_found) begin
                    wr_en                = 1'b1;
                    wr_addr              = cmp_idx;
                    wr_data              = cmp_rem;
                    n_res.status         = ST_DONE;
                    n_res.block_index    = idx_ext_best[INDEX_FIELD_W-1:0];
                    n_res.remaining_size = sz_ext_rem[SIZE_FIELD_W-1:0];
                end else begin
                    n_res.status = ST_NOFIT;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                // Hand the result to the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loaded    <= '0;
            r_reqs      <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_reqs      <= n_reqs;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= rd_en;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_scan   <= n_scan;
        r_rd_idx <= r_scan;
        r_req_sz <= n_req_sz;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule : best_fit_block_allocator
`default_nettype wire

[rtl/bfba_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfba_mem
// Free-block size table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfba_mem #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry, data valid in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule : bfba_mem
`default_nettype wire

[rtl/bfba_cmp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfba_cmp
// Shared compare unit: keeps the smallest entry that still fits the request,
// first index winning on ties, and forms the size left after allocation.
// ----------------------------------------------------------------------------
module bfba_cmp
    import bfba_pkg::*;
#(
    parameter int DATA_W = 16,
    parameter int IDX_W  = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmp_ctl          i_ctl,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic [IDX_W-1:0]  i_idx,
    input  wire logic [DATA_W-1:0] i_req,
    output logic                   o_found,
    output logic      [IDX_W-1:0]  o_best_idx,
    output logic      [DATA_W-1:0] o_remaining
);

    logic              r_found;
    logic [IDX_W-1:0]  r_best_idx;
    logic [DATA_W-1:0] r_best_size;
    logic              take;

    // Entry fits and beats the current candidate (strictly smaller)
    assign take = i_ctl.vld && (i_data >= i_req) && (!r_found || (i_data < r_best_size));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    // Hold the best candidate
    always_ff @(posedge i_clk) begin
        if (take && !i_ctl.start) begin
            r_best_idx  <= i_idx;
            r_best_size <= i_data;
        end
    end

    assign o_found     = r_found;
    assign o_best_idx  = r_best_idx;
    assign o_remaining = r_best_size - i_req;

endmodule : bfba_cmp
`default_nettype wire

[verif/tb_best_fit_block_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_best_fit_block_allocator
// Self-checking bench for the best-fit block allocator. A queue of commands
// (directed corner cases, random load/allocate traffic and a final run from
// a single large block) feeds a clocked driver. Every accepted command
// updates a local model of the block table, and the monitor compares each
// result field by field, in order, with the model.
// ----------------------------------------------------------------------------
module tb_best_fit_block_allocator;
    import bfba_pkg::*;

    localparam int TABLE_DEPTH   = BFBA_MAX_BLOCKS;
    localparam int RANDOM_ITEMS  = 530;
    localparam int CYCLE_LIMIT   = 5000000;
    localparam int QUIET_START   = 2000;
    localparam int QUIET_END     = 6000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    // Model of the allocator state
    logic [SIZE_FIELD_W-1:0] table_sizes [TABLE_DEPTH];
    int                      table_count = 0;
    logic [REQNUM_W-1:0]     request_count = '0;

    t_in_item  pending_items [$];
    t_out_item expected_results [$];
    int        fail_count = 0;
    int        cycle_count = 0;

    best_fit_block_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one command to the table model and return its result
    function automatic t_out_item best_fit_step(input t_in_item item);
        t_out_item res;
        int        best;
        res  = '0;
        best = -1;
        case (t_opcode'(item.opcode))
            OP_CLEAR: begin
                table_count   = 0;
                request_count = '0;
            end
            OP_APPEND: begin
                if (table_count >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    table_sizes[table_count] = item.size;
                    res.status         = ST_DONE;
                    res.block_index    = INDEX_FIELD_W'(table_count);
                    res.remaining_size = item.size;
                    table_count++;
                end
            end
            OP_ALLOC: begin
                request_count      = request_count + 1'b1;
                res.request_number = request_count;
                for (int i = 0; i < table_count; i++) begin
                    if (table_sizes[i] >= item.size &&
                        (best < 0 || table_sizes[i] < table_sizes[best])) begin
                        best = i;
                    end
                end
                if (best < 0) begin
                    res.status = ST_NOFIT;
                end else begin
                    table_sizes[best]  = table_sizes[best] - item.size;
                    res.status         = ST_DONE;
                    res.block_index    = INDEX_FIELD_W'(best);
                    res.remaining_size = table_sizes[best];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Random gaps, except in one quiet window
    function automatic bit take_break();
        if (cycle_count >= QUIET_START && cycle_count < QUIET_END) begin
            return 1'b0;
        end
        return $urandom_range(99) < 15;
    endfunction

    function automatic logic [SIZE_FIELD_W-1:0] pick_size(input int low_max);
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) begin
            return SIZE_FIELD_W'($urandom_range(low_max));
        end else if (roll < 75) begin
            return SIZE_FIELD_W'($urandom_range(65535));
        end else if (roll < 85) begin
            return 16'hFFFF - SIZE_FIELD_W'($urandom_range(3));
        end
        return SIZE_FIELD_W'($urandom_range(1024));
    endfunction

    task automatic push_item(input t_opcode op, input logic [SIZE_FIELD_W-1:0] sz);
        t_in_item item;
        item.opcode = op;
        item.size   = sz;
        pending_items.push_back(item);
    endtask

    // Mostly append and allocate traffic, with rare clears and ignored opcodes
    task automatic add_random_items(input int count);
        int roll;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                push_item(OP_CLEAR, SIZE_FIELD_W'($urandom_range(65535)));
            end else if (roll < 7) begin
                push_item(OP_NOP, SIZE_FIELD_W'($urandom_range(65535)));
            end else if (roll < 42) begin
                push_item(OP_APPEND, pick_size(31));
            end else begin
                push_item(OP_ALLOC, pick_size(15));
            end
        end
    endtask

    // Driver: predict on accept, then present the next command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(best_fit_step(in_item));
            end
            if (!in_valid || !in_stall) begin
                if (pending_items.size() != 0 && !take_break()) begin
                    in_item  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                fail_count <= fail_count + 1;
                if (fail_count < 10) begin
                    $display("ERROR: unexpected result %p", out_item);
                end
            end else begin
                exp_res = expected_results.pop_front();
                if (out_item.status !== exp_res.status ||
                    out_item.block_index !== exp_res.block_index ||
                    out_item.remaining_size !== exp_res.remaining_size ||
                    out_item.request_number !== exp_res.request_number) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) begin
                        $display("ERROR: result mismatch, expected %p, got %p",
                                 exp_res, out_item);
                    end
                end
            end
        end
        out_stall <= take_break();
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        // Directed: empty table, size extremes, zero request, ties, no fit
        push_item(OP_CLEAR, 16'h0000);
        push_item(OP_ALLOC, 16'h0005);
        push_item(OP_APPEND, 16'h0000);
        push_item(OP_APPEND, 16'hFFFF);
        push_item(OP_APPEND, 16'd100);
        push_item(OP_APPEND, 16'd100);
        push_item(OP_ALLOC, 16'h0000);
        push_item(OP_ALLOC, 16'd100);
        push_item(OP_ALLOC, 16'hFFFF);
        push_item(OP_ALLOC, 16'h0001);
        push_item(OP_NOP, 16'hFFFF);
        // Fill the table, then append once more to a full table
        for (int i = 4; i < TABLE_DEPTH; i++) begin
            push_item(OP_APPEND, (i[0] ? 16'h5555 : 16'hAAAA) ^ SIZE_FIELD_W'(i));
        end
        push_item(OP_APPEND, 16'h1234);
        push_item(OP_ALLOC, 16'hFFFF);
        push_item(OP_CLEAR, 16'hFFFF);

        add_random_items(RANDOM_ITEMS);

        // Restart from one large block, then more random traffic
        push_item(OP_CLEAR, 16'h0000);
        push_item(OP_APPEND, 16'hFFFF);
        add_random_items(40);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule : tb_best_fit_block_allocator
`default_nettype wire
